@@ hdl/sleu_pkg.sv @@
// Shared types, constants and helper functions of the string literal unescape block.
package sleu_pkg;

   localparam int MAX_RESULTS = 8;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int IDX_W       = $clog2(MAX_RESULTS);

   localparam logic [3:0] SHORT_LEN = 4'd4;
   localparam logic [3:0] LONG_LEN  = 4'd8;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] LC_B         = 8'h62;
   localparam logic [7:0] LC_F         = 8'h66;
   localparam logic [7:0] LC_N         = 8'h6E;
   localparam logic [7:0] LC_R         = 8'h72;
   localparam logic [7:0] LC_T         = 8'h74;
   localparam logic [7:0] LC_U         = 8'h75;

   localparam logic [1:0] ERR_NONE           = 2'd0;
   localparam logic [1:0] ERR_BAD_ESCAPE     = 2'd1;
   localparam logic [1:0] ERR_FEW_DIGITS     = 2'd2;
   localparam logic [1:0] ERR_BAD_CODE_POINT = 2'd3;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_HEX    = 2'd2,
      MODE_DROP   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] hex_value;
      logic [3:0]  hex_count;
      logic [7:0]  hex_upper;
   } state_type;

   localparam state_type STATE_RESET = '{MODE_NORMAL, 32'd0, 4'd0, 8'd0};

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_literal;
      logic [1:0] error_code;
   } entry_type;

   typedef struct packed {
      entry_type [MAX_RESULTS-1:0] entry;
      logic [CNT_W-1:0]            cnt;
   } list_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } utf8_type;

   typedef struct packed {
      logic [5:0][7:0] bytes;
      logic [2:0]      cnt;
      logic            bad;
   } flush_type;

   function automatic entry_type mk_entry(logic [7:0] b, logic valid, logic [1:0] err);
      entry_type e;
      e.out_byte       = b;
      e.byte_valid     = valid;
      e.end_of_literal = 1'b0;
      e.error_code     = err;
      return e;
   endfunction

   function automatic utf8_type utf8_enc(logic [20:0] cp);
      utf8_type u;
      u = '0;
      if (cp < 21'h80) begin
         u.bytes[0] = cp[7:0];
         u.len      = 3'd1;
      end else if (cp < 21'h800) begin
         u.bytes[0] = {3'b110, cp[10:6]};
         u.bytes[1] = {2'b10, cp[5:0]};
         u.len      = 3'd2;
      end else if (cp < 21'h10000) begin
         u.bytes[0] = {4'b1110, cp[15:12]};
         u.bytes[1] = {2'b10, cp[11:6]};
         u.bytes[2] = {2'b10, cp[5:0]};
         u.len      = 3'd3;
      end else begin
         u.bytes[0] = {5'b11110, cp[20:18]};
         u.bytes[1] = {2'b10, cp[17:12]};
         u.bytes[2] = {2'b10, cp[11:6]};
         u.bytes[3] = {2'b10, cp[5:0]};
         u.len      = 3'd4;
      end
      return u;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] d, logic upper);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = 8'h30 + {4'b0, d};
      end else begin
         c = (upper ? 8'h41 : 8'h61) + {4'b0, d} - 8'd10;
      end
      return c;
   endfunction

   // A run of four to seven digits: the first four form the code point and the
   // rest are given back as the characters they came in as.
   function automatic flush_type flush_short(logic [31:0] val, logic [2:0] cnt,
                                             logic [7:0] upper);
      flush_type  f;
      logic [15:0] cp;
      utf8_type   u;
      logic [2:0] idx;
      logic [2:0] extra;
      logic [1:0] j;
      logic [3:0] d;
      f = '0;
      case (cnt)
         3'd5:    cp = val[19:4];
         3'd6:    cp = val[23:8];
         3'd7:    cp = val[27:12];
         default: cp = val[15:0];
      endcase
      f.bad = (cp[15:11] == 5'b11011);
      u     = utf8_enc({5'b0, cp});
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < u.len) begin
            f.bytes[i] = u.bytes[i];
         end
      end
      extra = cnt - 3'd4;
      idx   = u.len;
      for (int k = 0; k < 3; k++) begin
         if (3'(k) < extra) begin
            j          = 2'(extra - 3'(k) - 3'd1);
            d          = val[4*j +: 4];
            f.bytes[idx] = hex_char(d, upper[4+k]);
            idx        = idx + 3'd1;
         end
      end
      f.cnt = idx;
      return f;
   endfunction

endpackage

@@ hdl/sleu_decode.sv @@
// Escape decoder: literal state registers and the per-byte result list logic.
module sleu_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [7:0]         ch,
   input  logic               last,
   output sleu_pkg::list_type list_out
);

   sleu_pkg::state_type st_ff;
   sleu_pkg::state_type st_in;

   logic [7:0]  lc;
   logic        is_hex;
   logic        is_up;
   logic [3:0]  dval;
   logic [31:0] val_upd;
   logic [3:0]  cnt_upd;
   logic [7:0]  up_upd;
   logic        long_bad;
   sleu_pkg::flush_type fl;
   sleu_pkg::utf8_type  u8;

   sleu_pkg::state_type nxt;
   sleu_pkg::list_type  res;
   logic [sleu_pkg::CNT_W-1:0] n;
   logic        failed;

   localparam logic [sleu_pkg::CNT_W-1:0] CNT_ONE = sleu_pkg::CNT_W'(1);

   always_comb begin
      lc     = (ch inside {[8'h41:8'h5A]}) ? ch + 8'h20 : ch;
      is_hex = 1'b1;
      is_up  = 1'b0;
      dval   = 4'd0;
      if (ch inside {[8'h30:8'h39]}) begin
         dval = 4'(ch - 8'h30);
      end else if (ch inside {[8'h61:8'h66]}) begin
         dval = 4'(ch - 8'h61 + 8'd10);
      end else if (ch inside {[8'h41:8'h46]}) begin
         dval  = 4'(ch - 8'h41 + 8'd10);
         is_up = 1'b1;
      end else begin
         is_hex = 1'b0;
      end
   end

   // Hex fields as they stand after this byte; equal to the stored ones unless
   // a digit is being gathered.
   always_comb begin
      val_upd = st_ff.hex_value;
      cnt_upd = st_ff.hex_count;
      up_upd  = st_ff.hex_upper;
      if (st_ff.mode == sleu_pkg::MODE_HEX && is_hex) begin
         val_upd = {st_ff.hex_value[27:0], dval};
         cnt_upd = st_ff.hex_count + 4'd1;
         if (is_up) begin
            up_upd[st_ff.hex_count[2:0]] = 1'b1;
         end
      end
   end

   assign fl       = sleu_pkg::flush_short(val_upd, cnt_upd[2:0], up_upd);
   assign u8       = sleu_pkg::utf8_enc(val_upd[20:0]);
   assign long_bad = (val_upd > 32'h0010FFFF) ||
                     (val_upd[31:16] == 16'd0 && val_upd[15:11] == 5'b11011);

   always_comb begin
      nxt    = st_ff;
      res    = '0;
      n      = '0;
      failed = 1'b0;
      if (st_ff.mode == sleu_pkg::MODE_DROP) begin
         if (last) begin
            res.entry[0] = sleu_pkg::mk_entry(8'h00, 1'b0, sleu_pkg::ERR_NONE);
            res.entry[0].end_of_literal = 1'b1;
            n   = CNT_ONE;
            nxt = sleu_pkg::STATE_RESET;
         end
      end else begin
         case (st_ff.mode)
            sleu_pkg::MODE_NORMAL: begin
               if (ch == sleu_pkg::CH_BACKSLASH) begin
                  nxt.mode = sleu_pkg::MODE_ESCAPE;
               end else begin
                  res.entry[n[sleu_pkg::IDX_W-1:0]] =
                     sleu_pkg::mk_entry(ch, 1'b1, sleu_pkg::ERR_NONE);
                  n = n + CNT_ONE;
               end
            end
            sleu_pkg::MODE_ESCAPE: begin
               nxt.mode = sleu_pkg::MODE_NORMAL;
               if (ch == sleu_pkg::CH_BACKSLASH || ch == sleu_pkg::CH_QUOTE ||
                   ch == sleu_pkg::CH_DQUOTE) begin
                  res.entry[0] = sleu_pkg::mk_entry(ch, 1'b1, sleu_pkg::ERR_NONE);
                  n = CNT_ONE;
               end else if (lc == sleu_pkg::LC_B) begin
                  res.entry[0] = sleu_pkg::mk_entry(sleu_pkg::CH_BS, 1'b1, sleu_pkg::ERR_NONE);
                  n = CNT_ONE;
               end else if (lc == sleu_pkg::LC_F) begin
                  res.entry[0] = sleu_pkg::mk_entry(sleu_pkg::CH_FF, 1'b1, sleu_pkg::ERR_NONE);
                  n = CNT_ONE;
               end else if (lc == sleu_pkg::LC_N) begin
                  res.entry[0] = sleu_pkg::mk_entry(sleu_pkg::CH_LF, 1'b1, sleu_pkg::ERR_NONE);
                  n = CNT_ONE;
               end else if (lc == sleu_pkg::LC_R) begin
                  res.entry[0] = sleu_pkg::mk_entry(sleu_pkg::CH_CR, 1'b1, sleu_pkg::ERR_NONE);
                  n = CNT_ONE;
               end else if (lc == sleu_pkg::LC_T) begin
                  res.entry[0] = sleu_pkg::mk_entry(sleu_pkg::CH_TAB, 1'b1, sleu_pkg::ERR_NONE);
                  n = CNT_ONE;
               end else if (lc == sleu_pkg::LC_U) begin
                  nxt.mode      = sleu_pkg::MODE_HEX;
                  nxt.hex_value = 32'd0;
                  nxt.hex_count = 4'd0;
                  nxt.hex_upper = 8'd0;
               end else begin
                  res.entry[0] = sleu_pkg::mk_entry(8'h00, 1'b0, sleu_pkg::ERR_BAD_ESCAPE);
                  n      = CNT_ONE;
                  failed = 1'b1;
               end
            end
            sleu_pkg::MODE_HEX: begin
               if (is_hex) begin
                  nxt.hex_value = val_upd;
                  nxt.hex_count = cnt_upd;
                  nxt.hex_upper = up_upd;
                  if (cnt_upd >= sleu_pkg::LONG_LEN) begin
                     nxt.mode = sleu_pkg::MODE_NORMAL;
                     if (long_bad) begin
                        res.entry[0] = sleu_pkg::mk_entry(8'h00, 1'b0,
                                                          sleu_pkg::ERR_BAD_CODE_POINT);
                        n      = CNT_ONE;
                        failed = 1'b1;
                     end else begin
                        for (int i = 0; i < 4; i++) begin
                           if (3'(i) < u8.len) begin
                              res.entry[n[sleu_pkg::IDX_W-1:0]] =
                                 sleu_pkg::mk_entry(u8.bytes[i], 1'b1, sleu_pkg::ERR_NONE);
                              n = n + CNT_ONE;
                           end
                        end
                     end
                  end
               end else if (st_ff.hex_count < sleu_pkg::SHORT_LEN) begin
                  res.entry[0] = sleu_pkg::mk_entry(8'h00, 1'b0, sleu_pkg::ERR_FEW_DIGITS);
                  n      = CNT_ONE;
                  failed = 1'b1;
               end else if (fl.bad) begin
                  res.entry[0] = sleu_pkg::mk_entry(8'h00, 1'b0,
                                                    sleu_pkg::ERR_BAD_CODE_POINT);
                  n      = CNT_ONE;
                  failed = 1'b1;
               end else begin
                  for (int i = 0; i < 6; i++) begin
                     if (3'(i) < fl.cnt) begin
                        res.entry[n[sleu_pkg::IDX_W-1:0]] =
                           sleu_pkg::mk_entry(fl.bytes[i], 1'b1, sleu_pkg::ERR_NONE);
                        n = n + CNT_ONE;
                     end
                  end
                  // The byte that ended the run is then taken as a plain byte.
                  if (ch == sleu_pkg::CH_BACKSLASH) begin
                     nxt.mode = sleu_pkg::MODE_ESCAPE;
                  end else begin
                     nxt.mode = sleu_pkg::MODE_NORMAL;
                     res.entry[n[sleu_pkg::IDX_W-1:0]] =
                        sleu_pkg::mk_entry(ch, 1'b1, sleu_pkg::ERR_NONE);
                     n = n + CNT_ONE;
                  end
               end
            end
            default: begin
            end
         endcase

         // An escape still open at the end of the literal is closed here.
         if (last && !failed) begin
            if (nxt.mode == sleu_pkg::MODE_ESCAPE) begin
               res.entry[n[sleu_pkg::IDX_W-1:0]] =
                  sleu_pkg::mk_entry(8'h00, 1'b0, sleu_pkg::ERR_BAD_ESCAPE);
               n      = n + CNT_ONE;
               failed = 1'b1;
            end else if (nxt.mode == sleu_pkg::MODE_HEX) begin
               if (nxt.hex_count < sleu_pkg::SHORT_LEN || fl.bad) begin
                  res.entry[n[sleu_pkg::IDX_W-1:0]] =
                     sleu_pkg::mk_entry(8'h00, 1'b0,
                        (nxt.hex_count < sleu_pkg::SHORT_LEN) ?
                        sleu_pkg::ERR_FEW_DIGITS : sleu_pkg::ERR_BAD_CODE_POINT);
                  n      = n + CNT_ONE;
                  failed = 1'b1;
               end else begin
                  for (int i = 0; i < 6; i++) begin
                     if (3'(i) < fl.cnt) begin
                        res.entry[n[sleu_pkg::IDX_W-1:0]] =
                           sleu_pkg::mk_entry(fl.bytes[i], 1'b1, sleu_pkg::ERR_NONE);
                        n = n + CNT_ONE;
                     end
                  end
               end
            end
         end

         if (last) begin
            if (n == '0) begin
               res.entry[0] = sleu_pkg::mk_entry(8'h00, 1'b0, sleu_pkg::ERR_NONE);
               n = CNT_ONE;
            end
            res.entry[sleu_pkg::IDX_W'(n - CNT_ONE)].end_of_literal = 1'b1;
            nxt = sleu_pkg::STATE_RESET;
         end else if (failed) begin
            nxt.mode = sleu_pkg::MODE_DROP;
         end
      end
      res.cnt = n;
   end

   assign st_in    = go ? nxt : st_ff;
   assign list_out = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= sleu_pkg::STATE_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

@@ hdl/sleu_outbuf.sv @@
// Result register: holds one byte's result list; gives one entry a cycle unless stalled.
module sleu_outbuf (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  sleu_pkg::list_type list_in,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output sleu_pkg::entry_type head,
   output logic               free
);

   sleu_pkg::entry_type entry_ff [sleu_pkg::MAX_RESULTS];
   sleu_pkg::entry_type entry_in [sleu_pkg::MAX_RESULTS];
   logic [sleu_pkg::CNT_W-1:0] cnt_ff;
   logic [sleu_pkg::CNT_W-1:0] cnt_in;
   logic [sleu_pkg::IDX_W-1:0] rd_ff;
   logic [sleu_pkg::IDX_W-1:0] rd_in;
   logic take;

   assign rsp_valid = (cnt_ff != '0);
   assign take      = rsp_valid && !rsp_stall;
   assign free      = (cnt_ff == '0) || (cnt_ff == sleu_pkg::CNT_W'(1) && take);
   assign head      = entry_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      for (int i = 0; i < sleu_pkg::MAX_RESULTS; i++) begin
         entry_in[i] = entry_ff[i];
      end
      if (load) begin
         cnt_in = list_in.cnt;
         rd_in  = '0;
         for (int i = 0; i < sleu_pkg::MAX_RESULTS; i++) begin
            entry_in[i] = list_in.entry[i];
         end
      end else if (take) begin
         cnt_in = cnt_ff - sleu_pkg::CNT_W'(1);
         rd_in  = rd_ff + sleu_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < sleu_pkg::MAX_RESULTS; i++) begin
         entry_ff[i] <= entry_in[i];
      end
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

endmodule

@@ hdl/string_literal_unescape_utf8.sv @@
// Top level of the string literal unescape block with UTF-8 output of unicode escapes.
//
// Usage: the req_ channel carries one content byte of a literal per transaction, quotes
// excluded, with req_last marking the literal's final byte. The rsp_ channel returns the
// decoded bytes, one per transaction; rsp_end_of_literal marks the last result of a
// literal, rsp_byte_valid is low on error reports and on a bare end marker, and
// rsp_error_code gives the error. Both channels use valid and stall.
// Path: an accepted byte waits in the input register, is decoded from there as its
// results are loaded into the result register, and they are offered from that register.
// Throughput: one byte per cycle while each byte yields at most one result and the
// receiver does not stall. A byte that yields n results (up to seven, for a unicode
// escape) occupies the result register while the list drains, and input stalls.
// Bytes that yield nothing (a backslash, hex digits being gathered, bytes dropped after
// an error) pass at one per cycle once earlier results have drained.
// Reset: synchronous and active high; it empties both registers and returns the decoder
// to its plain-byte state with no escape pending.
// Receiver stall: the result register holds its transaction; the input register then
// fills and req_stall rises, so nothing is lost.
module string_literal_unescape_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_literal,
   output logic [1:0] rsp_error_code
);

   // Input register.
   logic       a_valid_ff;
   logic       a_valid_in;
   logic [7:0] a_ch_ff;
   logic [7:0] a_ch_in;
   logic       a_last_ff;
   logic       a_last_in;

   logic                buf_free;
   logic                a_go;
   logic                req_take;
   sleu_pkg::list_type  list;
   sleu_pkg::entry_type head;

   // The held byte moves on as soon as the result register will be empty at the
   // next edge, either already empty or giving up its final transaction now.
   assign a_go      = a_valid_ff && buf_free;
   assign req_stall = a_valid_ff && !buf_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_ch_in    = a_ch_ff;
      a_last_in  = a_last_ff;
      if (req_take) begin
         a_valid_in = 1'b1;
         a_ch_in    = req_ch;
         a_last_in  = req_last;
      end else if (a_go) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      a_ch_ff   <= a_ch_in;
      a_last_ff <= a_last_in;
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   // Decoder state advances only when its byte's results are loaded.
   sleu_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .go       (a_go),
      .ch       (a_ch_ff),
      .last     (a_last_ff),
      .list_out (list)
   );

   sleu_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (a_go),
      .list_in   (list),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head      (head),
      .free      (buf_free)
   );

   assign rsp_out_byte       = head.out_byte;
   assign rsp_byte_valid     = head.byte_valid;
   assign rsp_end_of_literal = head.end_of_literal;
   assign rsp_error_code     = head.error_code;

endmodule

@@ tb/string_literal_unescape_utf8_tb.sv @@
// Self-checking testbench for the string literal unescape block with UTF-8 output.
`timescale 1ns / 100ps

module string_literal_unescape_utf8_tb;
   import sleu_pkg::*;

   // Random part of the run, and the watchdog limit in cycles with no transaction at all.
   localparam int RANDOM_ITEMS = 250;
   localparam int IDLE_LIMIT   = 2000;
   localparam int REPORT_MAX   = 10;
   // Accepted input count at which the receiver starts its long hold-off, and its length.
   localparam int HOLD_AT      = 120;
   localparam int HOLD_CYCLES  = 150;
   // Cycles allowed after the last expected result for anything stray to show up.
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } input_char_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_ch         = 8'h00;
   logic       req_last       = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_end_of_literal;
   logic [1:0] rsp_error_code;

   string_literal_unescape_utf8 dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_ch             (req_ch),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_end_of_literal (rsp_end_of_literal),
      .rsp_error_code     (rsp_error_code)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bytes still to be offered, the literal being assembled, and the decoded bytes that
   // the block still owes us, oldest first.
   input_char_type pending_chars[$];
   logic [7:0]     lit_bytes[$];
   entry_type      decoded_due[$];
   entry_type      char_results[$];

   int total_items    = 0;
   int accepted_items = 0;
   int mismatch_count = 0;
   int checked_count  = 0;

   // Appends one byte to the literal being assembled.
   function automatic void add_byte(logic [7:0] b);
      lit_bytes.insert(lit_bytes.size(), b);
   endfunction

   // ------------------------------------------------------------------------------------
   // Decoder state as the testbench sees it. It mirrors the block's own state, with the
   // per-digit case flags needed to give back surplus digits exactly as they came in.
   // ------------------------------------------------------------------------------------
   mode_type    dec_mode;
   logic [31:0] dec_hex;
   logic [3:0]  dec_cnt;
   logic        dec_err_seen;
   logic [7:0]  dec_upper;
   bit          char_failed;

   function automatic void clear_decoder();
      dec_mode     = MODE_NORMAL;
      dec_hex      = 32'd0;
      dec_cnt      = 4'd0;
      dec_err_seen = 1'b0;
      dec_upper    = 8'd0;
   endfunction

   function automatic void add_result(logic [7:0] b, logic valid, logic [1:0] err);
      entry_type r;
      r.out_byte       = b;
      r.byte_valid     = valid;
      r.end_of_literal = 1'b0;
      r.error_code     = err;
      char_results.insert(char_results.size(), r);
   endfunction

   // An error is a single data-less result carrying the code; the rest of the literal is
   // then thrown away.
   function automatic void report_error(logic [1:0] err);
      add_result(8'h00, 1'b0, err);
      char_failed = 1'b1;
   endfunction

   function automatic bit is_surrogate(logic [31:0] cp);
      return cp >= 32'h0000D800 && cp <= 32'h0000DFFF;
   endfunction

   function automatic void add_utf8(logic [31:0] cp);
      if (cp < 32'h80) begin
         add_result(cp[7:0], 1'b1, ERR_NONE);
      end else if (cp < 32'h800) begin
         add_result({3'b110, cp[10:6]}, 1'b1, ERR_NONE);
         add_result({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
      end else if (cp < 32'h10000) begin
         add_result({4'b1110, cp[15:12]}, 1'b1, ERR_NONE);
         add_result({2'b10, cp[11:6]}, 1'b1, ERR_NONE);
         add_result({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
      end else begin
         add_result({5'b11110, cp[20:18]}, 1'b1, ERR_NONE);
         add_result({2'b10, cp[17:12]}, 1'b1, ERR_NONE);
         add_result({2'b10, cp[11:6]}, 1'b1, ERR_NONE);
         add_result({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
      end
   endfunction

   // A run of four to seven digits: the oldest four are the code point, and the newer
   // ones go back out as plain characters in the case they arrived in.
   function automatic void flush_run();
      int          n;
      int          k;
      logic [31:0] cp;
      logic [3:0]  d;
      logic [7:0]  c;
      n  = dec_cnt[2:0];
      cp = (dec_hex >> (4 * (n - 4))) & 32'h0000FFFF;
      if (is_surrogate(cp)) begin
         report_error(ERR_BAD_CODE_POINT);
         return;
      end
      add_utf8(cp);
      for (k = 4; k < n; k++) begin
         d = 4'((dec_hex >> (4 * (n - 1 - k))) & 32'hF);
         if (d < 4'd10) begin
            c = 8'h30 + {4'd0, d};
         end else begin
            c = (dec_upper[k] ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
         end
         add_result(c, 1'b1, ERR_NONE);
      end
      dec_mode = MODE_NORMAL;
   endfunction

   function automatic void plain_char(logic [7:0] ch);
      if (ch == CH_BACKSLASH) begin
         dec_mode = MODE_ESCAPE;
      end else begin
         add_result(ch, 1'b1, ERR_NONE);
      end
   endfunction

   // Works out every result that one accepted input byte causes and queues them, in
   // order, behind whatever the block already owes.
   function automatic void decode_char(logic [7:0] ch, logic last);
      logic [7:0] lc;
      logic [3:0] d;
      bit         is_hex;
      bit         upper;
      entry_type  r;
      char_results.delete();
      char_failed = 1'b0;
      if (dec_mode == MODE_DROP || dec_err_seen) begin
         // Swallowing the tail of a failed literal; only its end is marked.
         if (last) begin
            add_result(8'h00, 1'b0, ERR_NONE);
            clear_decoder();
         end
      end else begin
         case (dec_mode)
            MODE_NORMAL: begin
               plain_char(ch);
            end
            MODE_ESCAPE: begin
               lc       = (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'h20 : ch;
               dec_mode = MODE_NORMAL;
               if (ch == CH_BACKSLASH || ch == CH_QUOTE || ch == CH_DQUOTE) begin
                  add_result(ch, 1'b1, ERR_NONE);
               end else if (lc == LC_B) begin
                  add_result(CH_BS, 1'b1, ERR_NONE);
               end else if (lc == LC_F) begin
                  add_result(CH_FF, 1'b1, ERR_NONE);
               end else if (lc == LC_N) begin
                  add_result(CH_LF, 1'b1, ERR_NONE);
               end else if (lc == LC_R) begin
                  add_result(CH_CR, 1'b1, ERR_NONE);
               end else if (lc == LC_T) begin
                  add_result(CH_TAB, 1'b1, ERR_NONE);
               end else if (lc == LC_U) begin
                  dec_mode  = MODE_HEX;
                  dec_hex   = 32'd0;
                  dec_cnt   = 4'd0;
                  dec_upper = 8'd0;
               end else begin
                  report_error(ERR_BAD_ESCAPE);
               end
            end
            default: begin
               is_hex = 1'b1;
               upper  = 1'b0;
               d      = 4'd0;
               if (ch >= 8'h30 && ch <= 8'h39) begin
                  d = ch[3:0];
               end else if (ch >= 8'h61 && ch <= 8'h66) begin
                  d = 4'(ch - 8'h57);
               end else if (ch >= 8'h41 && ch <= 8'h46) begin
                  d     = 4'(ch - 8'h37);
                  upper = 1'b1;
               end else begin
                  is_hex = 1'b0;
               end
               if (is_hex) begin
                  if (upper) begin
                     dec_upper[dec_cnt[2:0]] = 1'b1;
                  end
                  dec_hex = {dec_hex[27:0], d};
                  dec_cnt = dec_cnt + 4'd1;
                  // The eighth digit closes the escape straight away.
                  if (dec_cnt >= LONG_LEN) begin
                     dec_mode = MODE_NORMAL;
                     if (dec_hex > 32'h0010FFFF || is_surrogate(dec_hex)) begin
                        report_error(ERR_BAD_CODE_POINT);
                     end else begin
                        add_utf8(dec_hex);
                     end
                  end
               end else if (dec_cnt < SHORT_LEN) begin
                  report_error(ERR_FEW_DIGITS);
               end else begin
                  // The byte that ended the run is then taken as an ordinary byte.
                  flush_run();
                  if (!char_failed) begin
                     plain_char(ch);
                  end
               end
            end
         endcase
         // The end of the literal closes whatever escape is still open.
         if (last && !char_failed) begin
            if (dec_mode == MODE_ESCAPE) begin
               report_error(ERR_BAD_ESCAPE);
            end else if (dec_mode == MODE_HEX) begin
               if (dec_cnt < SHORT_LEN) begin
                  report_error(ERR_FEW_DIGITS);
               end else begin
                  flush_run();
               end
            end
         end
         if (last) begin
            if (char_results.size() == 0) begin
               add_result(8'h00, 1'b0, ERR_NONE);
            end
            clear_decoder();
         end else if (char_failed) begin
            dec_mode     = MODE_DROP;
            dec_err_seen = 1'b1;
         end
      end
      if (last) begin
         r                = char_results.pop_back();
         r.end_of_literal = 1'b1;
         char_results.insert(char_results.size(), r);
      end
      foreach (char_results[i]) begin
         decoded_due.insert(decoded_due.size(), char_results[i]);
      end
   endfunction

   // ------------------------------------------------------------------------------------
   // Stimulus helpers. A literal is built up byte by byte and then queued as a whole, the
   // mark going on its final byte.
   // ------------------------------------------------------------------------------------
   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i]);
      end
   endtask

   task automatic send_literal();
      input_char_type it;
      foreach (lit_bytes[i]) begin
         it.ch   = lit_bytes[i];
         it.last = (i == lit_bytes.size() - 1);
         pending_chars.insert(pending_chars.size(), it);
         total_items++;
      end
      lit_bytes.delete();
   endtask

   // Appends the low 'count' nibbles of a value, most significant first, each letter
   // digit in a random case.
   task automatic add_hex_digits(logic [31:0] value, int count);
      logic [3:0] d;
      for (int i = count - 1; i >= 0; i--) begin
         d = 4'((value >> (4 * i)) & 32'hF);
         if (d < 4'd10) begin
            add_byte(8'h30 + {4'd0, d});
         end else begin
            add_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10);
         end
      end
   endtask

   task automatic add_escape_u();
      add_byte(CH_BACKSLASH);
      add_byte($urandom_range(0, 1) ? LC_U : LC_U - 8'h20);
   endtask

   // A byte that cannot be a hex digit, to stop a digit run in the middle of a literal.
   task automatic add_run_stop();
      case ($urandom_range(0, 3))
         0:       add_byte(8'h20);
         1:       add_byte(8'($urandom_range(8'h80, 8'hFF)));
         2:       add_byte(CH_BACKSLASH);
         default: add_byte(8'($urandom_range(8'h67, 8'h7A)));
      endcase
   endtask

   // Code points over the UTF-8 lengths up to three bytes, the surrogate range and the
   // encoding boundaries; the wide set adds supplementary planes and values beyond them.
   function automatic logic [31:0] pick_code_point(bit wide);
      logic [31:0] cp;
      case ($urandom_range(0, wide ? 6 : 4))
         0: cp = $urandom_range(0, 32'h7F);
         1: cp = $urandom_range(32'h80, 32'h7FF);
         2: cp = $urandom_range(32'h800, 32'hFFFF);
         3: cp = $urandom_range(32'hD800, 32'hDFFF);
         4: begin
            case ($urandom_range(0, wide ? 9 : 5))
               0:       cp = 32'h0;
               1:       cp = 32'h7F;
               2:       cp = 32'h80;
               3:       cp = 32'h7FF;
               4:       cp = 32'h800;
               5:       cp = 32'hFFFF;
               6:       cp = 32'h10000;
               7:       cp = 32'h10FFFF;
               8:       cp = 32'h110000;
               default: cp = 32'hFFFFFFFF;
            endcase
         end
         5:       cp = $urandom_range(32'h10000, 32'h10FFFF);
         default: cp = $urandom();
      endcase
      return cp;
   endfunction

   // Mostly well-formed escapes with random content, with some noise and broken escapes
   // mixed in so that the error and drop paths see traffic too.
   task automatic build_random_literal();
      string escapes;
      int    segs;
      int    pick;
      bit    final_seg;
      escapes = "\\\"bfnrtBFNRT";
      segs    = $urandom_range(1, 8);
      for (int s = 0; s < segs; s++) begin
         final_seg = (s == segs - 1);
         pick      = $urandom_range(0, 99);
         if (pick < 22) begin
            add_byte(8'($urandom_range(0, 255)));
         end else if (pick < 40) begin
            add_byte(CH_BACKSLASH);
            pick = $urandom_range(0, escapes.len());
            add_byte(pick == escapes.len() ? CH_QUOTE : escapes[pick]);
         end else if (pick < 56) begin
            // Short form: four digits, up to three surplus ones, then a stop or the end.
            add_escape_u();
            add_hex_digits(pick_code_point(1'b0), 4);
            add_hex_digits($urandom(), $urandom_range(0, 3));
            if (!final_seg) begin
               add_run_stop();
            end
         end else if (pick < 72) begin
            add_escape_u();
            add_hex_digits(pick_code_point(1'b1), 8);
         end else if (pick < 78) begin
            // Digits past the eighth are ordinary bytes.
            add_escape_u();
            add_hex_digits(pick_code_point(1'b1), 8);
            add_hex_digits($urandom(), $urandom_range(1, 3));
         end else if (pick < 85) begin
            add_escape_u();
            add_hex_digits($urandom(), $urandom_range(0, 3));
            if (!final_seg) begin
               add_run_stop();
            end
         end else if (pick < 91) begin
            add_byte(CH_BACKSLASH);
            add_byte(8'($urandom_range(0, 255)));
         end else if (pick < 94) begin
            // A backslash with nothing after it when it ends the literal.
            add_byte(CH_BACKSLASH);
         end else begin
            for (int n = $urandom_range(1, 3); n > 0; n--) begin
               add_byte(8'($urandom_range(0, 255)));
            end
         end
      end
      send_literal();
   endtask

   // Waits until every queued byte has been taken and every expected result has arrived.
   task automatic wait_until_drained();
      @(posedge clock);
      while (accepted_items != total_items || decoded_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------------------------
   // Sender. Offers queued bytes in bursts of random length separated by random gaps;
   // a stalled transaction keeps its payload until it is taken. Each accepted byte is
   // run through the predictor at the edge that takes it.
   // ------------------------------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      input_char_type nxt_item;
      int             burst_left;
      int             gap_left;
      if (reset) begin
         req_valid  <= 1'b0;
         req_ch     <= 8'h00;
         req_last   <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_char(req_ch, req_last);
            accepted_items++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_chars.size() > 0) begin
               nxt_item = pending_chars.pop_front();
               req_valid <= 1'b1;
               req_ch    <= nxt_item.ch;
               req_last  <= nxt_item.last;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Receiver. Switches between stretches of no stall, light and heavy random stall and
   // an alternating pattern. Once, part-way through the random traffic, it holds off for
   // a long stretch so that the block backs up and stalls its input.
   // ------------------------------------------------------------------------------------
   always @(posedge clock) begin : stall_proc
      int hold_left;
      bit hold_done;
      int style;
      int style_left;
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_left  = 0;
         hold_done  = 1'b0;
         style      = 0;
         style_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && accepted_items >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (style_left == 0) begin
            style      = $urandom_range(0, 3);
            style_left = $urandom_range(10, 60);
         end else begin
            style_left--;
         end
         case (style)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // ------------------------------------------------------------------------------------
   // Checker. Every result transaction is compared field by field with the oldest
   // expected one; a result with nothing expected counts as a failure too.
   // ------------------------------------------------------------------------------------
   always @(posedge clock) begin : check_proc
      entry_type want;
      bit        have_want;
      if (!reset && rsp_valid && !rsp_stall) begin
         have_want = (decoded_due.size() != 0);
         want      = have_want ? decoded_due.pop_front() : '0;
         checked_count++;
         if (!have_want || rsp_out_byte !== want.out_byte ||
             rsp_byte_valid !== want.byte_valid ||
             rsp_end_of_literal !== want.end_of_literal ||
             rsp_error_code !== want.error_code) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
               $display("result %0d%s: expected %h/%b/%b/%0d got %h/%b/%b/%0d",
                        checked_count, have_want ? "" : " (none expected)",
                        want.out_byte, want.byte_valid, want.end_of_literal,
                        want.error_code, rsp_out_byte, rsp_byte_valid,
                        rsp_end_of_literal, rsp_error_code);
            end
         end
      end
   end

   // Ends the run if neither channel moves a transaction for too long.
   always @(posedge clock) begin : watchdog_proc
      int idle_cycles;
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin : stimulus_proc
      int directed_items;
      clear_decoder();

      // Plain bytes at both ends of the range, then every simple escape, letters in
      // either case, all in one literal that ends on an escape.
      add_byte(8'h00);
      add_byte(8'hFF);
      add_text("\\\\");
      add_byte(CH_BACKSLASH);
      add_byte(CH_QUOTE);
      add_byte(CH_BACKSLASH);
      add_byte(CH_DQUOTE);
      add_text("\\b\\F\\n\\R\\t");
      send_literal();
      // Code point zero, closed by the end of the literal after exactly four digits.
      add_text("\\u0000");
      send_literal();
      // A surrogate in mixed case stopped by a non-hex byte, then a dropped tail that
      // ends in a bare end marker.
      add_text("\\udFfF");
      add_byte(8'hFF);
      add_byte(8'h00);
      send_literal();
      // A backslash as the only and final byte.
      add_byte(CH_BACKSLASH);
      send_literal();
      directed_items = total_items;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Random literals are queued only once the block has returned everything it owes.
      wait_until_drained();

      while (total_items < directed_items + RANDOM_ITEMS) begin
         build_random_literal();
      end
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && decoded_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
